/* hdl/iir_impulse_response_generator_unit_macros.svh */
// assertion macros used by the impulse response generator checker
`ifndef IIR_IMPULSE_RESPONSE_GENERATOR_UNIT_MACROS_SVH
`define IIR_IMPULSE_RESPONSE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define IIRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// next-cycle implication, disabled while reset is asserted
`define IIRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

/* hdl/iirg_pkg.sv */
// types and constants of the impulse response generator
package iirg_pkg;

	localparam int MAX_ORDER  = 7;
	localparam int NUM_COEFS  = 8;
	localparam int COEF_W     = 16;
	localparam int TAP_W      = 32;
	localparam int COEF_FRAC  = 12;
	localparam int TAP_FRAC   = 20;
	localparam int IDX_W      = 16;
	localparam int ORDER_W    = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int DEN_HI_W   = 48;

	localparam int PROD_W     = COEF_W + TAP_W;
	localparam int NUM_TERM_W = COEF_W + TAP_FRAC;
	// headroom for the sum of all feedback terms plus the numerator term
	localparam int ACC_W      = ((PROD_W > NUM_TERM_W) ? PROD_W : NUM_TERM_W) + 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEN_LOW   = 3'd0,
		REG_DEN_HIGH  = 3'd1,
		REG_NUM_LOW   = 3'd2,
		REG_NUM_HIGH  = 3'd3,
		REG_NUM_ORDER = 3'd4,
		REG_DEN_ORDER = 3'd5,
		REG_TAP_COUNT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [MAX_ORDER*COEF_W-1:0] den_coefs;
		logic [NUM_COEFS*COEF_W-1:0] num_coefs;
		logic [ORDER_W-1:0]          num_order;
		logic [ORDER_W-1:0]          den_order;
		logic [IDX_W-1:0]            tap_count;
	} cfg_t;

	typedef struct packed {
		logic signed [TAP_W-1:0] tap_value;
		logic                    last_tap;
		logic                    saturated;
	} tap_res_t;

endpackage

/* hdl/iirg_ifs.sv */
// handshake channels of the impulse response generator
interface iirg_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface iirg_tap_if import iirg_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [TAP_W-1:0] tap_value;
	logic                    last_tap;
	logic                    saturated;

	modport source (output valid, output tap_value, output last_tap, output saturated,
		input ready);
	modport sink (input valid, input tap_value, input last_tap, input saturated,
		output ready);
endinterface

/* hdl/iirg_cfg_regs.sv */
// configuration register file of the impulse response generator
module iirg_cfg_regs import iirg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	output cfg_t                  cfg
);

	logic [CFG_DATA_W-1:0] den_low_q;
	logic [DEN_HI_W-1:0]   den_high_q;
	logic [CFG_DATA_W-1:0] num_low_q;
	logic [CFG_DATA_W-1:0] num_high_q;
	logic [ORDER_W-1:0]    num_order_q;
	logic [ORDER_W-1:0]    den_order_q;
	logic [IDX_W-1:0]      tap_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_low_q   <= '0;
			den_high_q  <= '0;
			num_low_q   <= CFG_DATA_W'(4096);
			num_high_q  <= '0;
			num_order_q <= '0;
			den_order_q <= ORDER_W'(1);
			tap_count_q <= IDX_W'(16);
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEN_LOW:   den_low_q   <= cfg_wr_data;
				REG_DEN_HIGH:  den_high_q  <= cfg_wr_data[DEN_HI_W-1:0];
				REG_NUM_LOW:   num_low_q   <= cfg_wr_data;
				REG_NUM_HIGH:  num_high_q  <= cfg_wr_data;
				REG_NUM_ORDER: num_order_q <= cfg_wr_data[ORDER_W-1:0];
				REG_DEN_ORDER: den_order_q <= cfg_wr_data[ORDER_W-1:0];
				REG_TAP_COUNT: tap_count_q <= cfg_wr_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.den_coefs = {den_high_q, den_low_q};
	assign cfg.num_coefs = {num_high_q, num_low_q};
	assign cfg.num_order = num_order_q;
	assign cfg.den_order = den_order_q;
	assign cfg.tap_count = tap_count_q;

endmodule

/* hdl/iirg_tap_calc.sv */
// one tap of the recursion: numerator term, feedback products, rounding, saturation
module iirg_tap_calc import iirg_pkg::*; (
	input  cfg_t                    cfg,
	input  logic signed [TAP_W-1:0] hist [MAX_ORDER],
	input  logic [IDX_W-1:0]        tap_index,
	output tap_res_t                res
);

	localparam logic signed [ACC_W-1:0] TMAX = ACC_W'({1'b0, {(TAP_W-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] TMIN = -TMAX - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) <<< (COEF_FRAC - 1);

	logic signed [COEF_W-1:0] b_coef;
	logic signed [COEF_W-1:0] a_coef [MAX_ORDER];
	logic signed [PROD_W-1:0] prod   [MAX_ORDER];
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  rnd;
	logic [IDX_W:0]           next_n;

	always_comb begin
		b_coef = '0;
		if (tap_index <= IDX_W'(cfg.num_order)) begin
			b_coef = cfg.num_coefs[tap_index[2:0]*COEF_W +: COEF_W];
		end
		acc = ACC_W'(b_coef) <<< TAP_FRAC;
		for (int m = 0; m < MAX_ORDER; m++) begin
			a_coef[m] = cfg.den_coefs[m*COEF_W +: COEF_W];
			// only delays up to both the order and the current tap number count
			if (ORDER_W'(m + 1) <= cfg.den_order && IDX_W'(m + 1) <= tap_index) begin
				prod[m] = a_coef[m] * hist[m];
			end else begin
				prod[m] = '0;
			end
			acc = acc - ACC_W'(prod[m]);
		end
		// round half up, then floor shift
		rnd = (acc + RND) >>> COEF_FRAC;
		res.saturated = 1'b0;
		if (rnd > TMAX) begin
			res.tap_value = TAP_W'(TMAX);
			res.saturated = 1'b1;
		end else if (rnd < TMIN) begin
			res.tap_value = TAP_W'(TMIN);
			res.saturated = 1'b1;
		end else begin
			res.tap_value = TAP_W'(rnd);
		end
		next_n = {1'b0, tap_index} + (IDX_W+1)'(1);
		res.last_tap = (next_n >= {1'b0, cfg.tap_count});
	end

endmodule

/* hdl/iirg_tap_state.sv */
// tap history delay line and tap counter
module iirg_tap_state import iirg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    restart,
	input  tap_res_t                res,
	output logic signed [TAP_W-1:0] hist [MAX_ORDER],
	output logic [IDX_W-1:0]        tap_index
);

	logic signed [TAP_W-1:0] hist_q [MAX_ORDER];
	logic [IDX_W-1:0]        index_q;

	// restart makes this tap number zero; the history is then never read
	assign tap_index = restart ? '0 : index_q;
	assign hist      = hist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			for (int k = 0; k < MAX_ORDER; k++) begin
				hist_q[k] <= '0;
			end
		end else if (advance) begin
			if (res.last_tap) begin
				index_q <= '0;
				for (int k = 0; k < MAX_ORDER; k++) begin
					hist_q[k] <= '0;
				end
			end else begin
				index_q   <= tap_index + IDX_W'(1);
				hist_q[0] <= res.tap_value;
				for (int k = 1; k < MAX_ORDER; k++) begin
					hist_q[k] <= restart ? '0 : hist_q[k-1];
				end
			end
		end
	end

endmodule

/* hdl/iirg_out_skid.sv */
// two-entry output buffer: result register plus skid entry
module iirg_out_skid import iirg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  tap_res_t     res,
	output logic         push_ready,
	iirg_tap_if.source   taps
);

	logic     out_valid_q;
	logic     skid_valid_q;
	tap_res_t out_q;
	tap_res_t skid_q;
	logic     load_out;

	assign push_ready = !skid_valid_q;
	assign load_out   = !out_valid_q || taps.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign taps.valid     = out_valid_q;
	assign taps.tap_value = out_q.tap_value;
	assign taps.last_tap  = out_q.last_tap;
	assign taps.saturated = out_q.saturated;

endmodule

/* hdl/iir_impulse_response_generator_unit.sv */
// Impulse response generator for a recursive filter, top level.
// Each tick transfer produces the next tap h[n] of the response, starting at n = 0; the tap is
// registered. One tick can be taken every clock, so the sustained rate is one tap per cycle while
// taps are accepted. The clock is set by the feedback path from the tap history through seven
// parallel 16x32 multiplies, their sum, rounding and saturation, back into the history. Two output
// entries let a tick be taken while one tap waits downstream; the tick channel stalls only when
// both are full. Coefficients are signed Q4.12, taps Q12.20. The user must write registers with
// cfg_wr_en, cfg_index and cfg_wr_data only while the block is idle; the block does not enforce it.
module iir_impulse_response_generator_unit import iirg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	iirg_tick_if.sink             tick,
	iirg_tap_if.source            taps
);

	cfg_t                    cfg;
	tap_res_t                res;
	logic signed [TAP_W-1:0] hist [MAX_ORDER];
	logic [IDX_W-1:0]        tap_index;
	logic                    tick_ready;
	logic                    advance;

	assign tick.ready = tick_ready;
	assign advance    = tick.valid && tick_ready;

	iirg_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	iirg_tap_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.restart   (tick.restart),
		.res       (res),
		.hist      (hist),
		.tap_index (tap_index)
	);

	iirg_tap_calc u_calc (
		.cfg       (cfg),
		.hist      (hist),
		.tap_index (tap_index),
		.res       (res)
	);

	iirg_out_skid u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (advance),
		.res        (res),
		.push_ready (tick_ready),
		.taps       (taps)
	);

endmodule

/* hdl/iirg_checker.sv */
// port-level checks of the impulse response generator and their binding
`include "iir_impulse_response_generator_unit_macros.svh"

module iirg_checker import iirg_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             tick_valid,
	input logic             tick_ready,
	input logic             taps_valid,
	input logic             taps_ready,
	input logic [TAP_W-1:0] taps_tap_value,
	input logic             taps_last_tap,
	input logic             taps_saturated
);

	// a stalled tap stays offered
	`IIRG_ASSERT_NXT(a_tap_held, clk, arst_n, taps_valid && !taps_ready, taps_valid)

	// a stalled tap keeps its payload
	`IIRG_ASSERT_NXT(a_tap_stable, clk, arst_n, taps_valid && !taps_ready, $stable(taps_tap_value) && $stable(taps_last_tap) && $stable(taps_saturated))

	// ticks are refused only while a tap is pending
	`IIRG_ASSERT_IMP(a_stall_needs_tap, clk, arst_n, !tick_ready, taps_valid)

	// an empty output fills only from a tick transfer in the previous cycle
	`IIRG_ASSERT_IMP(a_tap_from_tick, clk, arst_n, $rose(taps_valid), $past(tick_valid && tick_ready))

endmodule

bind iir_impulse_response_generator_unit iirg_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.tick_valid     (tick.valid),
	.tick_ready     (tick.ready),
	.taps_valid     (taps.valid),
	.taps_ready     (taps.ready),
	.taps_tap_value (taps.tap_value),
	.taps_last_tap  (taps.last_tap),
	.taps_saturated (taps.saturated)
);
